/* sv/tps_pkg.sv */
// ============================================================================
// tps_pkg: shared types and constants for the triangle plane slice unit
// Edge tables, pipeline side-band record and the radix-16 divider step.
// ============================================================================
package tps_pkg;

  // Edge order ab, bc, ca: mask bit, start vertex and end vertex.
  localparam logic [2:0] EDGE_BIT [3] = '{3'b001, 3'b010, 3'b100};
  localparam int EDGE_FROM [3] = '{0, 1, 2};
  localparam int EDGE_TO [3] = '{1, 2, 0};

  // Point pairs for the merge tests: (0,1), (0,2), (1,2).
  localparam int PAIR_A [3] = '{0, 0, 1};
  localparam int PAIR_B [3] = '{1, 2, 2};

  // Divider shape: 32 quotient bits, four bits per stage.
  localparam int DIV_BITS = 4;
  localparam int DIV_STAGES = 32 / DIV_BITS;

  // Side-band record that travels with every triangle down the pipeline.
  typedef struct packed {
    logic [2:0][31:0] vx;
    logic [2:0][31:0] vy;
    logic [2:0]       on;   // vertex lies on the plane
    logic [2:0]       neg;  // vertex lies below the plane
    logic [2:0]       nx;   // edge x difference is negative
    logic [2:0]       ny;   // edge y difference is negative
    logic [2:0]       vs;   // edge end vertices count as the same point
  } meta_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
  } div_t;

  // Magnitude of a 33-bit signed value known to stay below 2^32.
  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? (-v) : v;
    return t[31:0];
  endfunction

  // Four restoring division steps: shift in dividend bits, subtract if it fits.
  function automatic div_t div_step(input div_t cur, input logic [32:0] den);
    div_t        r;
    logic [33:0] t;
    r = cur;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r.rem, r.lo[31]};
      r.lo = {r.lo[30:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        r.q = {r.q[30:0], 1'b1};
      end else begin
        r.q = {r.q[30:0], 1'b0};
      end
      r.rem = t[32:0];
    end
    return r;
  endfunction

endpackage

/* sv/triangle_plane_slice_unit.sv */
// ============================================================================
// triangle_plane_slice_unit: cuts triangles with a horizontal plane
// Returns up to three 2D segments per triangle in signed Q16.16.
// ============================================================================
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/tready     triangle vertices and plane height
//  out_     out  out_tvalid/tready    one segment, tlast on the final one
//  cfg_     in   cfg_wr_en            tolerance (20 bits, reset 66)
//
// One triangle enters per cycle unless the output stalls. A triangle with
// several segments holds the output register until its last segment is taken,
// and the whole pipeline waits meanwhile.
// The crossing divider (eight stages of four quotient bits) sets the depth.
// Reset (synchronous, active low) clears valid bits and sets the tolerance.
// A stall on the output freezes every stage; nothing is dropped or repeated.
module triangle_plane_slice_unit (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
  //           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, plane_height
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [319:0] in_tdata,
  // out_tdata: start_x, start_y, end_x, end_y, source_edges, 5 zero bits
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,
  // out_tuser: has_segment
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [19:0]  cfg_wr_data
);

  localparam int DS = tps_pkg::DIV_STAGES;
  localparam int DIV_FIRST = 4;
  localparam int DIV_LAST = DIV_FIRST + DS - 1;
  localparam int LAST_ST = DIV_LAST + 4;

  logic        adv;
  logic [19:0] tol_r;
  logic [39:0] tol_sq_r;
  logic        v_r [1:LAST_ST];

  // Tolerance register and its square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 20'd66;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
    tol_sq_r <= tol_r * tol_r;
  end

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 1; t <= LAST_ST; t++) v_r[t] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_tvalid;
      for (int t = 2; t <= LAST_ST; t++) v_r[t] <= v_r[t-1];
    end
  end

  // Stage 1: heights above the plane and edge differences.
  logic [31:0]        s1_vx_r [3];
  logic [31:0]        s1_vy_r [3];
  logic signed [32:0] s1_d_r [3];
  logic signed [32:0] s1_dx_r [3];
  logic signed [32:0] s1_dy_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_vx_r[k] <= in_tdata[96*k +: 32];
        s1_vy_r[k] <= in_tdata[96*k+32 +: 32];
        s1_d_r[k]  <= $signed({in_tdata[96*k+95], in_tdata[96*k+64 +: 32]})
                    - $signed({in_tdata[319], in_tdata[288 +: 32]});
        s1_dx_r[k] <=
          $signed({in_tdata[96*tps_pkg::EDGE_TO[k]+31],
                   in_tdata[96*tps_pkg::EDGE_TO[k] +: 32]})
          - $signed({in_tdata[96*tps_pkg::EDGE_FROM[k]+31],
                     in_tdata[96*tps_pkg::EDGE_FROM[k] +: 32]});
        s1_dy_r[k] <=
          $signed({in_tdata[96*tps_pkg::EDGE_TO[k]+63],
                   in_tdata[96*tps_pkg::EDGE_TO[k]+32 +: 32]})
          - $signed({in_tdata[96*tps_pkg::EDGE_FROM[k]+63],
                     in_tdata[96*tps_pkg::EDGE_FROM[k]+32 +: 32]});
      end
    end
  end

  // Stage 2: magnitudes of heights and edge differences.
  tps_pkg::meta_t meta_r [2:LAST_ST];
  logic [31:0]    s2_md_r [3];
  logic [31:0]    s2_mdx_r [3];
  logic [31:0]    s2_mdy_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_md_r[k]  <= tps_pkg::mag33(s1_d_r[k]);
        s2_mdx_r[k] <= tps_pkg::mag33(s1_dx_r[k]);
        s2_mdy_r[k] <= tps_pkg::mag33(s1_dy_r[k]);
      end
    end
  end

  // Stage 3: crossing products and denominators, vertex distance squares.
  logic [63:0] s3_prod_r [6];
  logic [32:0] s3_den_r [3];
  logic        s3_near_r [3];
  logic [39:0] s3_sqx_r [3];
  logic [39:0] s3_sqy_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_prod_r[2*k]   <= s2_md_r[tps_pkg::EDGE_FROM[k]] * s2_mdx_r[k];
        s3_prod_r[2*k+1] <= s2_md_r[tps_pkg::EDGE_FROM[k]] * s2_mdy_r[k];
        s3_den_r[k]  <= {1'b0, s2_md_r[tps_pkg::EDGE_FROM[k]]}
                      + {1'b0, s2_md_r[tps_pkg::EDGE_TO[k]]};
        s3_near_r[k] <= (s2_mdx_r[k] <= {12'd0, tol_r}) &&
                        (s2_mdy_r[k] <= {12'd0, tol_r});
        s3_sqx_r[k]  <= s2_mdx_r[k][19:0] * s2_mdx_r[k][19:0];
        s3_sqy_r[k]  <= s2_mdy_r[k][19:0] * s2_mdy_r[k][19:0];
      end
    end
  end

  // Side-band record: built at stage 2 with on-plane and side flags, then
  // copied along; the vertex same tests are filled in at the first divider
  // stage.
  always_ff @(posedge clk) begin
    tps_pkg::meta_t m4;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        meta_r[2].vx[k]  <= s1_vx_r[k];
        meta_r[2].vy[k]  <= s1_vy_r[k];
        meta_r[2].on[k]  <= tps_pkg::mag33(s1_d_r[k]) <= {12'd0, tol_r};
        meta_r[2].neg[k] <= s1_d_r[k][32];
        meta_r[2].nx[k]  <= s1_dx_r[k][32];
        meta_r[2].ny[k]  <= s1_dy_r[k][32];
        meta_r[2].vs[k]  <= 1'b0;
      end
      for (int t = 3; t <= LAST_ST; t++) begin
        if (t != DIV_FIRST) begin
          meta_r[t] <= meta_r[t-1];
        end
      end
      m4 = meta_r[DIV_FIRST-1];
      for (int k = 0; k < 3; k++) begin
        m4.vs[k] = s3_near_r[k] &&
          (({1'b0, s3_sqx_r[k]} + {1'b0, s3_sqy_r[k]}) <= {1'b0, tol_sq_r});
      end
      meta_r[DIV_FIRST] <= m4;
    end
  end

  // Stages 4 to 11: pipelined restoring divider, four quotient bits a stage.
  tps_pkg::div_t dv_r  [DIV_FIRST:DIV_LAST][6];
  logic [32:0]   den_r [DIV_FIRST:DIV_LAST-1][3];

  always_ff @(posedge clk) begin
    tps_pkg::div_t init;
    if (adv) begin
      for (int c = 0; c < 6; c++) begin
        init.rem = {1'b0, s3_prod_r[c][63:32]};
        init.lo  = s3_prod_r[c][31:0];
        init.q   = 32'd0;
        dv_r[DIV_FIRST][c] <= tps_pkg::div_step(init, s3_den_r[c/2]);
        for (int t = DIV_FIRST + 1; t <= DIV_LAST; t++) begin
          dv_r[t][c] <= tps_pkg::div_step(dv_r[t-1][c], den_r[t-1][c/2]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        den_r[DIV_FIRST][k] <= s3_den_r[k];
        for (int t = DIV_FIRST + 1; t <= DIV_LAST - 1; t++) begin
          den_r[t][k] <= den_r[t-1][k];
        end
      end
    end
  end

  // Stage 12: one candidate point per edge (on-plane vertex or crossing).
  localparam int PT_ST = DIV_LAST + 1;
  logic [31:0] pcx_r [PT_ST:LAST_ST][3];
  logic [31:0] pcy_r [PT_ST:LAST_ST][3];
  logic [2:0]  pv_r  [PT_ST:LAST_ST];

  always_ff @(posedge clk) begin
    int          s, e;
    logic [31:0] qx, qy, crx, cry;
    tps_pkg::meta_t m;
    if (adv) begin
      m = meta_r[DIV_LAST];
      for (int k = 0; k < 3; k++) begin
        s   = tps_pkg::EDGE_FROM[k];
        e   = tps_pkg::EDGE_TO[k];
        qx  = dv_r[DIV_LAST][2*k].q;
        qy  = dv_r[DIV_LAST][2*k+1].q;
        crx = m.nx[k] ? (m.vx[s] - qx) : (m.vx[s] + qx);
        cry = m.ny[k] ? (m.vy[s] - qy) : (m.vy[s] + qy);
        if (m.on[s]) begin
          pcx_r[PT_ST][k] <= m.vx[s];
          pcy_r[PT_ST][k] <= m.vy[s];
        end else if (m.on[e]) begin
          pcx_r[PT_ST][k] <= m.vx[e];
          pcy_r[PT_ST][k] <= m.vy[e];
        end else begin
          pcx_r[PT_ST][k] <= crx;
          pcy_r[PT_ST][k] <= cry;
        end
        pv_r[PT_ST][k] <= (m.on[s] ^ m.on[e]) ||
                          (!m.on[s] && !m.on[e] && (m.neg[s] != m.neg[e]));
      end
      for (int t = PT_ST + 1; t <= LAST_ST; t++) begin
        pcx_r[t] <= pcx_r[t-1];
        pcy_r[t] <= pcy_r[t-1];
        pv_r[t]  <= pv_r[t-1];
      end
    end
  end

  // Stages 13 to 15: distance tests between candidate points.
  logic [31:0] pmx_r [3];
  logic [31:0] pmy_r [3];
  logic        pnear_r [3];
  logic [39:0] psqx_r [3];
  logic [39:0] psqy_r [3];
  logic [2:0]  ps_r;

  always_ff @(posedge clk) begin
    int a, b;
    if (adv) begin
      for (int p = 0; p < 3; p++) begin
        a = tps_pkg::PAIR_A[p];
        b = tps_pkg::PAIR_B[p];
        pmx_r[p] <= tps_pkg::mag33($signed({pcx_r[PT_ST][a][31], pcx_r[PT_ST][a]})
                                 - $signed({pcx_r[PT_ST][b][31], pcx_r[PT_ST][b]}));
        pmy_r[p] <= tps_pkg::mag33($signed({pcy_r[PT_ST][a][31], pcy_r[PT_ST][a]})
                                 - $signed({pcy_r[PT_ST][b][31], pcy_r[PT_ST][b]}));
        pnear_r[p] <= (pmx_r[p] <= {12'd0, tol_r}) && (pmy_r[p] <= {12'd0, tol_r});
        psqx_r[p]  <= pmx_r[p][19:0] * pmx_r[p][19:0];
        psqy_r[p]  <= pmy_r[p][19:0] * pmy_r[p][19:0];
        ps_r[p]    <= pnear_r[p] &&
          (({1'b0, psqx_r[p]} + {1'b0, psqy_r[p]}) <= {1'b0, tol_sq_r});
      end
    end
  end

  // Same-point lookup among vertices (edge tests) and among points (pairs).
  function automatic logic same_idx(input logic [1:0] i, input logic [1:0] j,
                                    input logic [2:0] t, input logic pairs);
    logic r;
    if (i == j) begin
      r = 1'b1;
    end else if ((i == 2'd0 && j == 2'd1) || (i == 2'd1 && j == 2'd0)) begin
      r = t[0];
    end else if ((i == 2'd1 && j == 2'd2) || (i == 2'd2 && j == 2'd1)) begin
      r = pairs ? t[2] : t[1];
    end else begin
      r = pairs ? t[1] : t[2];
    end
    return r;
  endfunction

  // Segment assembly: endpoint codes 0-2 are vertices, 4-6 are points.
  tps_pkg::meta_t mf;
  logic [31:0] src_x [8];
  logic [31:0] src_y [8];
  logic [2:0]  sgp [3];
  logic [2:0]  sgq [3];
  logic [2:0]  sgm [3];
  logic [1:0]  nseg;

  assign mf = meta_r[LAST_ST];

  always_comb begin
    logic [1:0] npt;
    logic [1:0] pidx [3];
    logic [2:0] pm [3];
    logic       found, fwd, rev;
    logic [1:0] ps_, qs_;
    found = 1'b0;
    fwd   = 1'b0;
    rev   = 1'b0;
    ps_   = 2'd0;
    qs_   = 2'd0;
    for (int i = 0; i < 8; i++) begin
      src_x[i] = 32'd0;
      src_y[i] = 32'd0;
    end
    for (int i = 0; i < 3; i++) begin
      src_x[i]   = mf.vx[i];
      src_y[i]   = mf.vy[i];
      src_x[4+i] = pcx_r[LAST_ST][i];
      src_y[4+i] = pcy_r[LAST_ST][i];
      sgp[i]  = 3'd0;
      sgq[i]  = 3'd0;
      sgm[i]  = 3'd0;
      pidx[i] = 2'd0;
      pm[i]   = 3'd0;
    end
    nseg = 2'd0;
    npt  = 2'd0;
    if (&mf.on) begin
      // All vertices on the plane: add each edge, dropping collapsed edges and repeats.
      for (int k = 0; k < 3; k++) begin
        ps_ = 2'(tps_pkg::EDGE_FROM[k]);
        qs_ = 2'(tps_pkg::EDGE_TO[k]);
        if (!mf.vs[k]) begin
          found = 1'b0;
          for (int i = 0; i < 3; i++) begin
            fwd = same_idx(sgp[i][1:0], ps_, mf.vs, 1'b0) &&
                  same_idx(sgq[i][1:0], qs_, mf.vs, 1'b0);
            rev = same_idx(sgp[i][1:0], qs_, mf.vs, 1'b0) &&
                  same_idx(sgq[i][1:0], ps_, mf.vs, 1'b0);
            if (i < nseg && !found && (fwd || rev)) begin
              sgm[i] = sgm[i] | tps_pkg::EDGE_BIT[k];
              found  = 1'b1;
            end
          end
          if (!found) begin
            sgp[nseg] = {1'b0, ps_};
            sgq[nseg] = {1'b0, qs_};
            sgm[nseg] = tps_pkg::EDGE_BIT[k];
            nseg      = nseg + 2'd1;
          end
        end
      end
    end else begin
      // Gather points in edge order, merging close ones.
      for (int k = 0; k < 3; k++) begin
        if (pv_r[LAST_ST][k]) begin
          found = 1'b0;
          for (int i = 0; i < 3; i++) begin
            if (i < npt && !found && same_idx(pidx[i], 2'(k), ps_r, 1'b1)) begin
              pm[i] = pm[i] | tps_pkg::EDGE_BIT[k];
              found = 1'b1;
            end
          end
          if (!found && npt != 2'd3) begin
            pidx[npt] = 2'(k);
            pm[npt]   = tps_pkg::EDGE_BIT[k];
            npt       = npt + 2'd1;
          end
        end
      end
      // An edge lying on the plane becomes the segment unless it collapses.
      for (int k = 0; k < 3; k++) begin
        if (mf.on[tps_pkg::EDGE_FROM[k]] && mf.on[tps_pkg::EDGE_TO[k]] &&
            !mf.vs[k] && nseg == 2'd0) begin
          sgp[0] = 3'(tps_pkg::EDGE_FROM[k]);
          sgq[0] = 3'(tps_pkg::EDGE_TO[k]);
          sgm[0] = tps_pkg::EDGE_BIT[k];
          nseg   = 2'd1;
        end
      end
      // Two distinct points and no segment yet: join them.
      if (nseg == 2'd0 && npt == 2'd2) begin
        sgp[0] = {1'b1, pidx[0]};
        sgq[0] = {1'b1, pidx[1]};
        sgm[0] = pm[0] | pm[1];
        nseg   = 2'd1;
      end
    end
  end

  // Output register: holds one triangle's results and sends them in order.
  logic        res_valid_r;
  logic        res_has_r;
  logic [1:0]  res_lastidx_r;
  logic [1:0]  res_sel_r;
  logic [31:0] res_sx_r [3];
  logic [31:0] res_sy_r [3];
  logic [31:0] res_ex_r [3];
  logic [31:0] res_ey_r [3];
  logic [2:0]  res_m_r [3];

  assign out_tvalid = res_valid_r;
  assign out_tlast  = res_sel_r == res_lastidx_r;
  assign out_tuser  = res_has_r;
  assign adv        = !res_valid_r || (out_tready && out_tlast);
  assign in_tready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_sel_r   <= 2'd0;
    end else if (adv) begin
      res_valid_r <= v_r[LAST_ST];
      res_sel_r   <= 2'd0;
    end else if (out_tready) begin
      res_sel_r <= res_sel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_has_r     <= nseg != 2'd0;
      res_lastidx_r <= (nseg == 2'd0) ? 2'd0 : nseg - 2'd1;
      for (int i = 0; i < 3; i++) begin
        res_sx_r[i] <= (nseg == 2'd0) ? 32'd0 : src_x[sgp[i]];
        res_sy_r[i] <= (nseg == 2'd0) ? 32'd0 : src_y[sgp[i]];
        res_ex_r[i] <= (nseg == 2'd0) ? 32'd0 : src_x[sgq[i]];
        res_ey_r[i] <= (nseg == 2'd0) ? 32'd0 : src_y[sgq[i]];
        res_m_r[i]  <= (nseg == 2'd0) ? 3'd0 : sgm[i];
      end
    end
  end

  assign out_tdata = {5'd0, res_m_r[res_sel_r], res_ey_r[res_sel_r],
                      res_ex_r[res_sel_r], res_sy_r[res_sel_r],
                      res_sx_r[res_sel_r]};

  // A no-cut result stands alone.
  a_nocut_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("no-cut result is not the last one");

  // Every real segment names at least one source edge.
  a_seg_has_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[130:128] != 3'd0))
    else $error("segment without source edge");

  // The result pointer never runs past the stored count.
  a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_sel_r <= res_lastidx_r))
    else $error("result pointer past last result");

  // Having sent a non-final result, the next one belongs to the same triangle.
  a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tuser))
    else $error("segment burst broken");

endmodule

/* test/triangle_plane_slice_unit_tb.sv */
// ============================================================================
// triangle_plane_slice_unit_tb: self-checking bench for the plane slice unit
// Drives triangles with random idle gaps, predicts the cut segments of each
// one in the bench and compares every output item field by field in order.
// ============================================================================
module triangle_plane_slice_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [319:0] data;
    logic         is_cfg;
    logic [19:0]  tol;
  } tri_item_t;

  typedef struct {
    logic        has;
    logic [31:0] sx, sy, ex, ey;
    logic [2:0]  edges;
    logic        last;
  } seg_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [319:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en = 1'b0;
  logic [19:0]  cfg_wr_data = '0;

  tri_item_t   pending_tris[$];
  seg_result_t expected_segs[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned idle_cycles = 0;
  logic        stim_done = 1'b0;
  logic [19:0] model_tol = 20'd66;

  triangle_plane_slice_unit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Two points match when each axis and the squared distance are in tolerance.
  function automatic bit points_match(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, t;
    dx = ax - bx; if (dx < 0) dx = -dx;
    dy = ay - by; if (dy < 0) dy = -dy;
    t = longint'(model_tol);
    if (dx > t || dy > t) return 0;
    return dx * dx + dy * dy <= t * t;
  endfunction

  // Crossing coordinate, quotient truncated toward zero.
  function automatic longint crossing(longint s, longint e, longint ds, longint de);
    logic [127:0] num;
    logic [127:0] q;
    longint diff, ads, ade;
    diff = e - s;
    ads = ds < 0 ? -ds : ds;
    ade = de < 0 ? -de : de;
    num = 128'(ads) * 128'(diff < 0 ? -diff : diff);
    q = num / 128'(ads + ade);
    return diff < 0 ? s - longint'(q) : s + longint'(q);
  endfunction

  // Work out the segments of one triangle and queue them.
  task automatic predict_slice(input logic [319:0] d);
    longint vx[3], vy[3], dz[3], h;
    bit on[3];
    longint sg[3][4], pt[3][2];
    logic [2:0] sm[3], pm[3];
    int nseg, npt, oncnt, s, e;
    logic [2:0] eb;
    longint cx, cy;
    seg_result_t r;
    nseg = 0; npt = 0; oncnt = 0;
    h = longint'($signed(d[319:288]));
    for (int k = 0; k < 3; k++) begin
      vx[k] = longint'($signed(d[96*k +: 32]));
      vy[k] = longint'($signed(d[96*k+32 +: 32]));
      dz[k] = longint'($signed(d[96*k+64 +: 32])) - h;
      on[k] = (dz[k] < 0 ? -dz[k] : dz[k]) <= longint'(model_tol);
      if (on[k]) oncnt++;
    end
    for (int k = 0; k < 4; k++) begin
      longint px, py, qx, qy;
      bit hit, merged;
      hit = 0;
      if (k < 3) begin
        s = k; e = (k + 1) % 3; eb = 3'b001 << k;
        if (oncnt == 3 || (on[s] && on[e])) begin
          px = vx[s]; py = vy[s]; qx = vx[e]; qy = vy[e]; hit = 1;
        end else if (on[s] || on[e] || ((dz[s] < 0) != (dz[e] < 0))) begin
          if (on[s]) begin cx = vx[s]; cy = vy[s]; end
          else if (on[e]) begin cx = vx[e]; cy = vy[e]; end
          else begin
            cx = crossing(vx[s], vx[e], dz[s], dz[e]);
            cy = crossing(vy[s], vy[e], dz[s], dz[e]);
          end
          merged = 0;
          for (int i = 0; i < npt; i++)
            if (!merged && points_match(pt[i][0], pt[i][1], cx, cy)) begin
              pm[i] |= eb; merged = 1;
            end
          if (!merged && npt < 3) begin
            pt[npt][0] = cx; pt[npt][1] = cy; pm[npt] = eb; npt++;
          end
        end
      end else if (oncnt != 3 && nseg == 0 && npt == 2) begin
        px = pt[0][0]; py = pt[0][1]; qx = pt[1][0]; qy = pt[1][1];
        eb = pm[0] | pm[1]; hit = 1;
      end
      // Drop degenerate segments and fold duplicates into earlier ones.
      if (hit && !points_match(px, py, qx, qy)) begin
        merged = 0;
        for (int i = 0; i < nseg; i++)
          if (!merged && ((points_match(sg[i][0], sg[i][1], px, py) &&
                           points_match(sg[i][2], sg[i][3], qx, qy)) ||
                          (points_match(sg[i][0], sg[i][1], qx, qy) &&
                           points_match(sg[i][2], sg[i][3], px, py)))) begin
            sm[i] |= eb; merged = 1;
          end
        if (!merged && nseg < 3) begin
          sg[nseg][0] = px; sg[nseg][1] = py; sg[nseg][2] = qx; sg[nseg][3] = qy;
          sm[nseg] = eb; nseg++;
        end
      end
    end
    if (nseg == 0) begin
      r = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0, 1'b1};
      expected_segs.insert(expected_segs.size(), r);
    end
    for (int i = 0; i < nseg; i++) begin
      r.has = 1'b1;
      r.sx = sg[i][0][31:0]; r.sy = sg[i][1][31:0];
      r.ex = sg[i][2][31:0]; r.ey = sg[i][3][31:0];
      r.edges = sm[i]; r.last = (i == nseg - 1);
      expected_segs.insert(expected_segs.size(), r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [319:0] pack_tri(input logic [31:0] f[10]);
    logic [319:0] d;
    for (int i = 0; i < 10; i++) d[32*i +: 32] = f[i];
    return d;
  endfunction

  // Vertex z values near the plane, on it, or far away, with random x and y.
  function automatic logic [319:0] random_tri(input logic [19:0] tol);
    logic [31:0] f[10];
    int h;
    h = $urandom_range(0, 7) == 0 ? $urandom : $signed($urandom_range(0, 65535 * 16)) - 500000;
    f[9] = h;
    for (int k = 0; k < 3; k++) begin
      f[3*k]   = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21);
      f[3*k+1] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21);
      case ($urandom_range(0, 5))
        0: f[3*k+2] = h + $signed($urandom_range(0, 2 * tol)) - $signed({12'd0, tol});
        1: f[3*k+2] = h;
        2: f[3*k+2] = $urandom;
        default: f[3*k+2] = h + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
    end
    return pack_tri(f);
  endfunction

  task automatic add_tri(input logic [31:0] f[10]);
    tri_item_t t;
    t.data = pack_tri(f); t.is_cfg = 1'b0; t.tol = '0;
    pending_tris.insert(pending_tris.size(), t);
  endtask

  task automatic add_cfg(input logic [19:0] tol);
    tri_item_t t;
    t.data = '0; t.is_cfg = 1'b1; t.tol = tol;
    pending_tris.insert(pending_tris.size(), t);
  endtask

  // Build the stimulus: directed triangles, then random phases per tolerance.
  initial begin
    logic [31:0] f[10];
    logic [19:0] tols[5];
    tri_item_t t;
    tols = '{20'd0, 20'hFFFFF, 20'd66, 20'd4096, 20'd1};
    // All on plane, and a tiny all-on-plane triangle (degenerate edges).
    f = '{0, 0, 100, 65536, 0, 100, 0, 65536, 100, 100}; add_tri(f);
    f = '{0, 0, 5, 10, 0, 5, 0, 10, 5, 5}; add_tri(f);
    // One edge on plane, third vertex above.
    f = '{0, 0, 0, 65536, 65536, 0, 0, 65536, 65536, 0}; add_tri(f);
    // One vertex on plane, crossing on the opposite edge.
    f = '{0, 0, 0, 65536, 0, 65536, 0, 65536, -65536, 0}; add_tri(f);
    // Only a vertex touches the plane.
    f = '{0, 0, 0, 65536, 0, 65536, 0, 65536, 65536, 0}; add_tri(f);
    // Two crossings with negative differences, and fully above (no cut).
    f = '{-3, 7, -65536, 65535, -131072, 196608, -99999, 12345, 65536, 0}; add_tri(f);
    f = '{0, 0, 65536, 1, 1, 65536, 2, 2, 65536, 0}; add_tri(f);
    // Field extremes.
    f = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
          32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF}; add_tri(f);
    f = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
          32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0}; add_tri(f);
    f = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}; add_tri(f);
    // Edges that meet at an on-plane vertex give the same point, and it is merged.
    f = '{0, 0, 50, 0, 0, -70, 65536, 0, 200, 0}; add_tri(f);
    for (int p = 0; p < 5; p++) begin
      add_cfg(tols[p]);
      for (int i = 0; i < 23; i++) begin
        t.data = random_tri(tols[p]); t.is_cfg = 1'b0; t.tol = '0;
        pending_tris.insert(pending_tris.size(), t);
      end
      f = '{0, 0, 32'(tols[p]), 0, 65536, 0, 65536, 0, 0, 0}; add_tri(f);
    end
    stim_done = 1'b1;
  end

  // Reset, then watch for completion or a hang.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && pending_tris.size() == 0 && expected_segs.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_segs.size() == 0)
      $display("triangle_plane_slice_unit test passed");
    else
      $display("triangle_plane_slice_unit test failed");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("triangle_plane_slice_unit test failed");
      $finish;
    end
  end

  // Driver: one item per handshake, random gaps, register writes only when idle.
  always @(posedge clk) begin
    logic        took;
    int unsigned gap;
    tri_item_t   nx;
    if (rst_n) begin
      took = in_tvalid && in_tready;
      gap  = send_wait;
      if (took) begin
        predict_slice(in_tdata);
        void'(pending_tris.pop_front());
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      end
      if (in_tvalid && !in_tready) begin
        // Hold the item until accepted.
        cfg_wr_en <= 1'b0;
      end else if (gap != 0) begin
        in_tvalid <= 1'b0;
        cfg_wr_en <= 1'b0;
        send_wait <= gap - 1;
      end else if (pending_tris.size() != 0) begin
        nx = pending_tris[0];
        if (nx.is_cfg) begin
          in_tvalid <= 1'b0;
          if (!took && expected_segs.size() == 0 && idle_cycles >= 24) begin
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= nx.tol;
            model_tol = nx.tol;
            void'(pending_tris.pop_front());
          end else begin
            cfg_wr_en <= 1'b0;
          end
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= nx.data;
          cfg_wr_en <= 1'b0;
        end
      end else begin
        in_tvalid <= 1'b0;
        cfg_wr_en <= 1'b0;
      end
    end
  end

  // Cycles since the last results, so a register write waits out the pipeline.
  always @(posedge clk)
    idle_cycles <= (in_tvalid || expected_segs.size() != 0) ? 0 : idle_cycles + 1;

  // Monitor: random backpressure, compare each segment with the oldest prediction.
  always @(posedge clk) begin
    seg_result_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_segs.size() == 0) begin
          report_mismatch("unexpected item", out_tdata[31:0], 32'd0);
        end else begin
          w = expected_segs.pop_front();
          if (out_tuser !== w.has)
            report_mismatch("has_segment", 32'(out_tuser), 32'(w.has));
          if (out_tdata[31:0] !== w.sx) report_mismatch("start_x", out_tdata[31:0], w.sx);
          if (out_tdata[63:32] !== w.sy) report_mismatch("start_y", out_tdata[63:32], w.sy);
          if (out_tdata[95:64] !== w.ex) report_mismatch("end_x", out_tdata[95:64], w.ex);
          if (out_tdata[127:96] !== w.ey) report_mismatch("end_y", out_tdata[127:96], w.ey);
          if (out_tdata[130:128] !== w.edges)
            report_mismatch("source_edges", 32'(out_tdata[130:128]), 32'(w.edges));
          if (out_tlast !== w.last)
            report_mismatch("last_segment", 32'(out_tlast), 32'(w.last));
        end
        recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end
endmodule

/* files.f */
sv/tps_pkg.sv
sv/triangle_plane_slice_unit.sv
test/triangle_plane_slice_unit_tb.sv
